// ----- design/klaw_pkg.sv -----
package klaw_pkg;

	localparam int MaxLanes  = 3;
	localparam int LanesDef  = 3;
	localparam int ValW      = 16;
	localparam int SumW      = 35;
	localparam int FullTurn  = 'h1000;
	localparam int WrapLimit = 'h801;
	localparam int WrapSpan  = 'h10;

	typedef struct packed {
		logic                   mode;
		logic signed [15:0]     now_time;
		logic        [15:0]     span;
		logic signed [15:0]     from_0;
		logic signed [15:0]     from_1;
		logic signed [15:0]     from_2;
		logic signed [15:0]     to_0;
		logic signed [15:0]     to_1;
		logic signed [15:0]     to_2;
	} klaw_in_t;

	typedef struct packed {
		logic                   skipped;
		logic signed [15:0]     out_0;
		logic signed [15:0]     out_1;
		logic signed [15:0]     out_2;
	} klaw_out_t;

endpackage

// ----- design/keyframe_lerp_with_angle_wrap.sv -----
// Keyframe interpolator: takes one triple per cycle (start while busy is low;
// busy never rises) and returns (to*t + from*(span-t))/span per lane,
// truncated toward zero, low 16 bits, with the angle wrap rule for span 16
// in angle mode. The item passes the wrap, multiply and sum stages, then
// the divider operand load stage and the bit-per-stage divider stages.
// Results come with done for one cycle and cannot be stalled. Zero span
// gives skipped with zero values.
module keyframe_lerp_with_angle_wrap #(
	parameter int LANES = klaw_pkg::LanesDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  klaw_pkg::klaw_in_t   item_in,
	output logic                 done,
	output klaw_pkg::klaw_out_t  item_out
);
	import klaw_pkg::*;

	localparam int MagW = SumW - 1;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	logic signed [15:0] from_in [MaxLanes];
	logic signed [15:0] to_in   [MaxLanes];
	assign from_in[0] = item_in.from_0;
	assign from_in[1] = item_in.from_1;
	assign from_in[2] = item_in.from_2;
	assign to_in[0]   = item_in.to_0;
	assign to_in[1]   = item_in.to_1;
	assign to_in[2]   = item_in.to_2;

	// stage 1: wrap rule on start values
	logic               vld_s1;
	logic               skip_s1;
	logic signed [16:0] t_s1;
	logic signed [17:0] rest_s1;
	logic        [15:0] span_s1;
	logic signed [17:0] from_s1 [MaxLanes];
	logic signed [15:0] to_s1   [MaxLanes];

	logic wrap_on;
	assign wrap_on = item_in.mode && (item_in.span == 16'(WrapSpan));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= accept;
	end

	for (genvar k = 0; k < MaxLanes; k++) begin : g_wrap
		logic signed [17:0] f, d, ad, w;
		always_comb begin
			f  = 18'(from_in[k]);
			d  = 18'(to_in[k]) - f;
			ad = d[17] ? -d : d;
			w  = f;
			if (wrap_on && ad >= 18'(WrapLimit))
				w = (f <= 0) ? f + 18'(FullTurn) : f - 18'(FullTurn);
		end
		always_ff @(posedge clk) begin
			from_s1[k] <= w;
			to_s1[k]   <= to_in[k];
		end
	end

	always_ff @(posedge clk) begin
		skip_s1 <= (item_in.span == '0);
		t_s1    <= 17'(item_in.now_time);
		rest_s1 <= 18'($signed({2'b00, item_in.span})) - 18'(item_in.now_time);
		span_s1 <= item_in.span;
	end

	// stage 2: products
	logic               vld_s2;
	logic               skip_s2;
	logic        [15:0] span_s2;
	logic signed [33:0] pa_s2 [MaxLanes];
	logic signed [35:0] pb_s2 [MaxLanes];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		skip_s2 <= skip_s1;
		span_s2 <= span_s1;
	end

	for (genvar k = 0; k < MaxLanes; k++) begin : g_mul
		always_ff @(posedge clk) begin
			pa_s2[k] <= 34'(to_s1[k]) * 34'(t_s1);
			pb_s2[k] <= 36'(from_s1[k]) * 36'(rest_s1);
		end
	end

	// stage 3: sum, then divider per lane
	logic               vld_s3;
	logic        [15:0] span_s3;
	logic signed [SumW-1:0] sum_s3 [MaxLanes];
	logic [MagW+1:0]    skip_line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		span_s3 <= skip_s2 ? 16'd1 : span_s2;
	end

	// skip flag travels alongside the divider
	always_ff @(posedge clk) begin
		skip_line_q <= {skip_line_q[MagW:0], skip_s2};
	end

	logic        dv_valid [MaxLanes];
	logic [15:0] dv_quot  [MaxLanes];

	for (genvar k = 0; k < MaxLanes; k++) begin : g_lane
		logic signed [35:0] s;
		assign s = 36'(pa_s2[k]) + pb_s2[k];
		always_ff @(posedge clk) begin
			sum_s3[k] <= skip_s2 ? '0 : s[SumW-1:0];
		end
		klaw_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld_s3),
			.dividend (sum_s3[k]),
			.divisor  (span_s3),
			.out_valid(dv_valid[k]),
			.quot_low (dv_quot[k])
		);
	end

	// output select, unused lanes read zero
	logic [15:0] res [MaxLanes];
	for (genvar k = 0; k < MaxLanes; k++) begin : g_res
		assign res[k] = (k < LANES && !skip_line_q[MagW+1]) ? dv_quot[k] : '0;
	end

	assign done              = dv_valid[0];
	assign item_out.skipped  = skip_line_q[MagW+1];
	assign item_out.out_0    = res[0];
	assign item_out.out_1    = res[1];
	assign item_out.out_2    = res[2];

	// lanes stay in step
	a_lanes_sync: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid[0] == dv_valid[2]) else $error("lanes out of step");
	// a result needs an accepted item behind it
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 38)) else $error("result without item");
	// skipped results carry zeros
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && item_out.skipped) |-> (item_out.out_0 == '0 && item_out.out_2 == '0))
		else $error("skip result not zero");
endmodule

// ----- design/klaw_div.sv -----
// pipelined restoring divider: magnitude of a signed sum over an unsigned span,
// one quotient bit per stage, sign fixed at the end (truncation toward zero)
module klaw_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [klaw_pkg::SumW-1:0] dividend,
	input  logic        [15:0]            divisor,
	output logic                          out_valid,
	output logic        [15:0]            quot_low
);
	import klaw_pkg::*;

	localparam int MagW = SumW - 1;

	logic [MagW:0]   vld_q;
	logic [MagW-1:0] num_q  [MagW+1];
	logic [16:0]     rem_q  [MagW+1];
	logic [15:0]     dvs_q  [MagW+1];
	logic            neg_q  [MagW+1];

	logic [SumW-1:0] mag_in;
	assign mag_in = dividend[SumW-1] ? (~dividend + 1'b1) : dividend;

	// valid shift line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[MagW-1:0], in_valid};
		end
	end

	// stage 0 loads operands
	always_ff @(posedge clk) begin
		num_q[0] <= mag_in[MagW-1:0];
		rem_q[0] <= '0;
		dvs_q[0] <= divisor;
		neg_q[0] <= dividend[SumW-1];
	end

	// one quotient bit per stage, quotient shifts into num
	for (genvar i = 0; i < MagW; i++) begin : g_stage
		logic [17:0] trial;
		logic [17:0] shifted;
		assign shifted = {rem_q[i], num_q[i][MagW-1]};
		assign trial   = shifted - {2'b00, dvs_q[i]};
		always_ff @(posedge clk) begin
			dvs_q[i+1] <= dvs_q[i];
			neg_q[i+1] <= neg_q[i];
			if (!trial[17]) begin
				rem_q[i+1] <= trial[16:0];
				num_q[i+1] <= {num_q[i][MagW-2:0], 1'b1};
			end else begin
				rem_q[i+1] <= shifted[16:0];
				num_q[i+1] <= {num_q[i][MagW-2:0], 1'b0};
			end
		end
	end

	logic [15:0] mag_low;
	assign mag_low   = num_q[MagW][15:0];
	assign quot_low  = neg_q[MagW] ? (~mag_low + 1'b1) : mag_low;
	assign out_valid = vld_q[MagW];
endmodule

// ----- bench/keyframe_lerp_with_angle_wrap_tb.sv -----
`timescale 1ns / 100ps

module keyframe_lerp_with_angle_wrap_tb;
	import klaw_pkg::*;

	localparam int Latency  = 38;
	localparam int DogLimit = 4000;
	localparam int RandItems = 500;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	klaw_in_t  item_in;
	logic      done;
	klaw_out_t item_out;

	int        mismatches;
	int        n_sent;
	int        n_wrapped;
	int        n_skipped;
	int        idle_cycles;

	keyframe_lerp_with_angle_wrap dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item_in  (item_in),
		.done     (done),
		.item_out (item_out)
	);

	// one lane of the interpolation, with the wrap rule
	function automatic logic signed [15:0] lerp_lane(logic angle, logic signed [15:0] t,
			logic [15:0] dur, logic signed [15:0] a, logic signed [15:0] b);
		longint from_v;
		longint to_v;
		longint diff;
		longint sum;
		longint q;
		from_v = a;
		to_v   = b;
		if (angle && dur == 16'(WrapSpan)) begin
			diff = to_v - from_v;
			if (diff < 0)
				diff = -diff;
			if (diff >= WrapLimit)
				from_v = (from_v <= 0) ? from_v + FullTurn : from_v - FullTurn;
		end
		sum = to_v * longint'(t) + from_v * (longint'(dur) - longint'(t));
		q = sum / longint'(dur);
		return q[15:0];
	endfunction

	function automatic klaw_out_t interpolate(klaw_in_t x);
		klaw_out_t r;
		r = '0;
		if (x.span == 0) begin
			r.skipped = 1'b1;
		end else begin
			r.out_0 = lerp_lane(x.mode, x.now_time, x.span, x.from_0, x.to_0);
			r.out_1 = lerp_lane(x.mode, x.now_time, x.span, x.from_1, x.to_1);
			r.out_2 = lerp_lane(x.mode, x.now_time, x.span, x.from_2, x.to_2);
		end
		return r;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	class lerp_scoreboard;
		klaw_out_t pending[$];

		function void note_item(klaw_in_t x);
			pending.push_back(interpolate(x));
		endfunction

		task check_result(klaw_out_t got);
			klaw_out_t want;
			if (pending.size() == 0) begin
				report("unexpected result", int'(got.out_0), 0);
			end else begin
				want = pending.pop_front();
				if (got.skipped !== want.skipped)
					report("skipped", got.skipped, want.skipped);
				if (got.out_0 !== want.out_0)
					report("out_0", got.out_0, want.out_0);
				if (got.out_1 !== want.out_1)
					report("out_1", got.out_1, want.out_1);
				if (got.out_2 !== want.out_2)
					report("out_2", got.out_2, want.out_2);
			end
		endtask
	endclass

	lerp_scoreboard sb;

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(item_out);
	end

	// watchdog on cycles with no traffic
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= DogLimit) begin
			$display("watchdog expired");
			$display("Verification failed");
			$finish;
		end
	end

	// one item, held until accepted
	task automatic send_item(klaw_in_t x);
		start   <= 1'b1;
		item_in <= x;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_item(x);
		n_sent++;
		if (x.span == 0)
			n_skipped++;
		if (x.mode && x.span == 16'(WrapSpan))
			n_wrapped++;
	endtask

	task automatic pause(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_val();
		case ($urandom_range(0, 5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 8)) - 16'd4;
			3: return 16'($urandom_range(0, 16'h1fff)) - 16'h1000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic klaw_in_t rand_item();
		klaw_in_t x;
		x.mode = 1'($urandom);
		case ($urandom_range(0, 9))
			0: x.span = '0;
			1, 2, 3: x.span = 16'(WrapSpan);
			4: x.span = 16'hffff;
			5: x.span = 16'($urandom);
			default: x.span = 16'($urandom_range(1, 64));
		endcase
		if ($urandom_range(0, 3) == 0)
			x.now_time = 16'($urandom);
		else
			x.now_time = 16'($urandom_range(0, x.span));
		x.from_0 = rand_val();
		x.from_1 = rand_val();
		x.from_2 = rand_val();
		x.to_0   = rand_val();
		x.to_1   = rand_val();
		x.to_2   = rand_val();
		// angle-like content in the wrap range
		if (x.mode && $urandom_range(0, 1)) begin
			x.from_0 = 16'($urandom_range(0, 16'h1fff)) - 16'h1000;
			x.to_0   = 16'($urandom_range(0, 16'h1fff)) - 16'h1000;
		end
		return x;
	endfunction

	function automatic klaw_in_t make_item(logic m, int t, int d, int f, int g);
		klaw_in_t x;
		x.mode = m;
		x.now_time = 16'(t);
		x.span = 16'(d);
		x.from_0 = 16'(f);
		x.from_1 = 16'(-f);
		x.from_2 = 16'(g);
		x.to_0 = 16'(g);
		x.to_1 = 16'(-g);
		x.to_2 = 16'(f);
		return x;
	endfunction

	initial begin
		int burst;
		sb = new();
		mismatches = 0;
		n_sent = 0;
		n_wrapped = 0;
		n_skipped = 0;
		idle_cycles = 0;
		arst_n  = 1'b0;
		start   = 1'b0;
		item_in = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, zero span, wrap boundaries, extrapolation
		send_item(make_item(0, 0, 0, 100, 200));
		send_item(make_item(1, 5, 0, -32768, 32767));
		send_item(make_item(0, 0, 1, 32767, -32768));
		send_item(make_item(0, 1, 1, 32767, -32768));
		send_item(make_item(0, 32767, 65535, -32768, 32767));
		send_item(make_item(0, -32768, 65535, 32767, -32768));
		send_item(make_item(0, -32768, 1, 32767, 32767));
		send_item(make_item(0, 32767, 2, -32768, 32767));
		send_item(make_item(1, 8, 16, 0, 'h801));
		send_item(make_item(1, 8, 16, 0, 'h800));
		send_item(make_item(1, 8, 16, 1, 'h802));
		send_item(make_item(1, 8, 16, 'h801, 0));
		send_item(make_item(1, 4, 16, -'h801, 0));
		send_item(make_item(1, 4, 16, 'h7ff, -1));
		send_item(make_item(1, 8, 17, 0, 'h900));
		send_item(make_item(0, 8, 16, 0, 'h900));
		send_item(make_item(1, 0, 16, -32768, 32767));
		send_item(make_item(1, 16, 16, 32767, -32768));
		send_item(make_item(1, -100, 16, 100, -3000));
		send_item(make_item(0, 20000, 3, -7, 9));
		send_item(make_item(0, 3, 7, -1, 1));
		send_item(make_item(0, -3, 7, 1, -1));

		// drain once before the random part
		pause(1);
		while (sb.pending.size() != 0)
			@(posedge clk);

		// random bursts with gaps
		while (n_sent < RandItems + 22) begin
			burst = $urandom_range(1, 40);
			repeat (burst)
				send_item(rand_item());
			if ($urandom_range(0, 2) != 0)
				pause($urandom_range(1, 45));
		end
		start <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (Latency + 5) @(posedge clk);

		$display("sent %0d items: %0d zero span, %0d in angle wrap range",
			n_sent, n_skipped, n_wrapped);
		$display("mismatches found: %0d", mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/klaw_pkg.sv
design/klaw_div.sv
design/keyframe_lerp_with_angle_wrap.sv
bench/keyframe_lerp_with_angle_wrap_tb.sv
